// ----- design/rsc_pkg.sv -----
package rsc_pkg;

	typedef logic [63:0] word_t;

	localparam int MAX_POSITIONS_DEF = 16384;
	localparam int MAX_HEAD_DIM_DEF = 256;

	localparam word_t LOG2_10K_Q60 = 64'hD49A784BCD1B8AFE;
	localparam word_t LN2_Q64 = 64'hB17217F7D1CF79AC;
	localparam word_t INV_2PI_Q64 = 64'h28BE60DB9391054A;
	localparam word_t HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam word_t ONE_Q62 = 64'h4000000000000000;
	localparam word_t ONE_Q63 = 64'h8000000000000000;

	localparam logic SERIES_EXP = 1'b0;
	localparam logic SERIES_TRIG = 1'b1;

	localparam logic REG_HEAD_DIM = 1'b0;
	localparam logic REG_CONVENTION = 1'b1;

endpackage

// ----- design/rsc_div.sv -----
module rsc_div #(
	parameter int NW = 64,
	parameter int DW = 9,
	parameter int STEP = 4,
	parameter int SBW = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  logic [NW-1:0]  num_i,
	input  logic [DW-1:0]  den_i,
	input  logic [SBW-1:0] sb_i,
	output logic           valid_o,
	output logic [NW-1:0]  quo_o,
	output logic [SBW-1:0] sb_o
);
	import rsc_pkg::*;

	localparam int STAGES = NW / STEP;

	logic           valid_s [STAGES+1];
	logic [NW-1:0]  work_s [STAGES+1];
	logic [DW-1:0]  rem_s [STAGES+1];
	logic [DW-1:0]  den_s [STAGES+1];
	logic [SBW-1:0] sb_s [STAGES+1];

	assign valid_s[0] = valid_i;
	assign work_s[0] = num_i;
	assign rem_s[0] = '0;
	assign den_s[0] = den_i;
	assign sb_s[0] = sb_i;

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [NW-1:0] work_c;
		logic [DW-1:0] rem_c;
		logic [DW:0]   trial;

		always_comb begin
			work_c = work_s[j];
			rem_c = rem_s[j];
			trial = '0;
			for (int b = 0; b < STEP; b++) begin
				trial = {rem_c, work_c[NW-1]};
				work_c = {work_c[NW-2:0], 1'b0};
				if (trial >= {1'b0, den_s[j]}) begin
					trial = trial - {1'b0, den_s[j]};
					work_c[0] = 1'b1;
				end
				rem_c = trial[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			work_s[j+1] <= work_c;
			rem_s[j+1] <= rem_c;
			den_s[j+1] <= den_s[j];
			sb_s[j+1] <= sb_s[j];
		end
	end

	assign valid_o = valid_s[STAGES];
	assign quo_o = work_s[STAGES];
	assign sb_o = sb_s[STAGES];

endmodule

// ----- design/rsc_mul64.sv -----
module rsc_mul64 #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  rsc_pkg::word_t a_i,
	input  rsc_pkg::word_t b_i,
	input  logic [SBW-1:0] sb_i,
	output logic           valid_o,
	output logic [127:0]   prod_o,
	output logic [SBW-1:0] sb_o
);
	import rsc_pkg::*;

	logic           valid_s1, valid_s2;
	word_t          ll_s1, lh_s1, hl_s1, hh_s1;
	logic [SBW-1:0] sb_s1, sb_s2;
	logic [127:0]   prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ll_s1 <= {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
		lh_s1 <= {32'b0, a_i[31:0]} * {32'b0, b_i[63:32]};
		hl_s1 <= {32'b0, a_i[63:32]} * {32'b0, b_i[31:0]};
		hh_s1 <= {32'b0, a_i[63:32]} * {32'b0, b_i[63:32]};
		sb_s1 <= sb_i;
		prod_s2 <= {64'b0, ll_s1} + {32'b0, lh_s1, 32'b0} + {32'b0, hl_s1, 32'b0}
			+ {hh_s1, 64'b0};
		sb_s2 <= sb_s1;
	end

	assign valid_o = valid_s2;
	assign prod_o = prod_s2;
	assign sb_o = sb_s2;

endmodule

// ----- design/rsc_term.sv -----
module rsc_term #(
	parameter int K = 1,
	parameter logic SERIES = rsc_pkg::SERIES_EXP,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  rsc_pkg::word_t term_i,
	input  rsc_pkg::word_t mult_i,
	input  rsc_pkg::word_t acc0_i,
	input  rsc_pkg::word_t acc1_i,
	input  logic [SBW-1:0] sb_i,
	output logic           valid_o,
	output rsc_pkg::word_t term_o,
	output rsc_pkg::word_t mult_o,
	output rsc_pkg::word_t acc0_o,
	output rsc_pkg::word_t acc1_o,
	output logic [SBW-1:0] sb_o
);
	import rsc_pkg::*;

	localparam int KM = K % 4;
	localparam int SH = $clog2(K);
	localparam logic [127:0] RCP = ((128'd1 << (64 + SH)) / 128'(K)) + 128'd1;
	localparam word_t RCP_LO = RCP[63:0];
	localparam int CW = 3 * 64 + SBW;
	localparam int RW = CW + 64;

	logic           valid_m;
	logic [127:0]   prod_m;
	logic [CW-1:0]  carry_m;
	word_t          prod_sel;

	logic           valid_r;
	logic [127:0]   prod_r;
	logic [RW-1:0]  carry_r;
	logic [64:0]    qsum;
	word_t          quo;

	logic           valid_s3, valid_s4;
	word_t          term_s3, mult_s3, acc0_s3, acc1_s3;
	word_t          term_s4, mult_s4, acc0_s4, acc1_s4;
	logic [SBW-1:0] sb_s3, sb_s4;
	word_t          acc0_n, acc1_n;

	rsc_mul64 #(.SBW(CW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_i),
		.a_i     (term_i),
		.b_i     (mult_i),
		.sb_i    ({acc0_i, acc1_i, mult_i, sb_i}),
		.valid_o (valid_m),
		.prod_o  (prod_m),
		.sb_o    (carry_m)
	);

	assign prod_sel = (SERIES == SERIES_TRIG) ? prod_m[125:62] : prod_m[127:64];

	// The quotient by the constant K is the high part of a product with its
	// 65-bit reciprocal, whose leading one is added back as the dividend itself.
	rsc_mul64 #(.SBW(RW)) u_rcp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_m),
		.a_i     (prod_sel),
		.b_i     (RCP_LO),
		.sb_i    ({prod_sel, carry_m}),
		.valid_o (valid_r),
		.prod_o  (prod_r),
		.sb_o    (carry_r)
	);

	assign qsum = {1'b0, carry_r[RW-1 -: 64]} + {1'b0, prod_r[127:64]};
	assign quo = word_t'(qsum >> SH);

	always_comb begin
		acc0_n = acc0_s3;
		acc1_n = acc1_s3;
		if (SERIES == SERIES_TRIG) begin
			if (KM == 1) begin
				acc0_n = acc0_s3 + term_s3;
			end else if (KM == 2) begin
				acc1_n = acc1_s3 - term_s3;
			end else if (KM == 3) begin
				acc0_n = acc0_s3 - term_s3;
			end else begin
				acc1_n = acc1_s3 + term_s3;
			end
		end else if ((K % 2) == 1) begin
			acc0_n = acc0_s3 + term_s3;
		end else begin
			acc0_n = acc0_s3 - term_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_r;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		term_s3 <= quo;
		acc0_s3 <= carry_r[CW-1 -: 64];
		acc1_s3 <= carry_r[CW-65 -: 64];
		mult_s3 <= carry_r[CW-129 -: 64];
		sb_s3 <= carry_r[SBW-1:0];
		term_s4 <= term_s3;
		mult_s4 <= mult_s3;
		acc0_s4 <= acc0_n;
		acc1_s4 <= acc1_n;
		sb_s4 <= sb_s3;
	end

	assign valid_o = valid_s4;
	assign term_o = term_s4;
	assign mult_o = mult_s4;
	assign acc0_o = acc0_s4;
	assign acc1_o = acc1_s4;
	assign sb_o = sb_s4;

endmodule

// ----- design/rope_sin_cos_generator_top.sv -----
// Channel   Direction  Signals                               Transfer
// command   in         start, busy, position, dim_index      start high while busy low
// result    out        done, sine_out, cosine_out            done high for one cycle
// config    in/out     psel, penable, pwrite, paddr, pwdata  psel, penable, pwrite, pready
//
// One item enters every cycle; busy stays low. Each result's delay from the edge that
// accepts its command to done is set by the pipeline depth: a 16-stage divider,
// the exponent and sine/cosine series at six stages per term, the 64-bit multipliers
// at two stages each and three single registers. Reset clears the valid bits and loads
// head_dim 128 and convention 1. The receiver cannot stall, so the pipeline never holds.
module rope_sin_cos_generator_top #(
	parameter int MAX_POSITIONS = rsc_pkg::MAX_POSITIONS_DEF,
	parameter int MAX_HEAD_DIM = rsc_pkg::MAX_HEAD_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [13:0]        position,
	input  logic [7:0]         dim_index,
	output logic               done,
	output logic signed [15:0] sine_out,
	output logic signed [15:0] cosine_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rsc_pkg::*;

	localparam int HW = ($clog2(MAX_HEAD_DIM + 1) > 9) ? $clog2(MAX_HEAD_DIM + 1) : 9;
	localparam logic [HW-1:0] HD_MAX = HW'(MAX_HEAD_DIM - (MAX_HEAD_DIM % 2));
	localparam int EXP_TERMS = 19;
	localparam int TRIG_TERMS = 27;

	logic [8:0] head_dim_q;
	logic [1:0] convention_q;

	logic [HW-1:0] hd_c, len_c, half_c, e_c, i_c;
	logic [13:0]   pos_c;

	logic          valid_s1;
	word_t         num_s1;
	logic [HW-1:0] len_s1;
	logic [13:0]   pos_s1;

	logic          div_valid;
	word_t         div_quo;
	logic [13:0]   div_pos;

	logic          t_valid;
	logic [127:0]  t_prod;
	logic [13:0]   t_pos;

	logic          y_valid;
	logic [127:0]  y_prod;
	logic [29:0]   y_sb;

	logic          e_valid [EXP_TERMS+1];
	word_t         e_term [EXP_TERMS+1];
	word_t         e_mult [EXP_TERMS+1];
	word_t         e_acc0 [EXP_TERMS+1];
	word_t         e_acc1 [EXP_TERMS+1];
	logic [29:0]   e_sb [EXP_TERMS+1];

	logic          inv_valid;
	logic [127:0]  inv_prod;
	logic [29:0]   inv_sb;

	logic          valid_s2;
	word_t         turns_s2;
	logic [13:0]   pos_s2;

	logic          ph_valid;
	logic [127:0]  ph_prod;

	logic          th_valid;
	logic [127:0]  th_prod;
	logic [1:0]    th_quad;

	logic          c_valid [TRIG_TERMS+1];
	word_t         c_term [TRIG_TERMS+1];
	word_t         c_mult [TRIG_TERMS+1];
	word_t         c_acc0 [TRIG_TERMS+1];
	word_t         c_acc1 [TRIG_TERMS+1];
	logic [1:0]    c_sb [TRIG_TERMS+1];

	logic signed [15:0] sv_c, cv_c, sin_c, cos_c;

	logic               valid_s3;
	logic signed [15:0] sin_s3, cos_s3;

	function automatic logic signed [15:0] round_q14(input word_t v);
		word_t c;
		word_t r;
		begin
			c = v;
			if (v[63]) begin
				c = '0;
			end else if (v > ONE_Q62) begin
				c = ONE_Q62;
			end
			r = (c + 64'h0000800000000000) >> 48;
			return r[15:0];
		end
	endfunction

	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_dim_q <= 9'd128;
			convention_q <= 2'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HEAD_DIM: head_dim_q <= pwdata[8:0];
				REG_CONVENTION: convention_q <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HEAD_DIM: prdata = {23'b0, head_dim_q};
			REG_CONVENTION: prdata = {30'b0, convention_q};
		endcase
	end

	always_comb begin
		hd_c = HW'({head_dim_q[8:1], 1'b0});
		if (hd_c < HW'(2)) begin
			hd_c = HW'(2);
		end else if (hd_c > HD_MAX) begin
			hd_c = HD_MAX;
		end
		len_c = convention_q[1] ? (hd_c >> 1) : hd_c;
		half_c = len_c >> 1;
		e_c = HW'({dim_index[7:1], 1'b0});
		if (convention_q == 2'd0) begin
			i_c = e_c >> 1;
		end else if (e_c >= half_c) begin
			i_c = e_c - half_c;
		end else begin
			i_c = e_c;
		end
		pos_c = (32'(position) >= MAX_POSITIONS) ? 14'(MAX_POSITIONS - 1) : position;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= inv_valid;
			valid_s3 <= c_valid[TRIG_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= word_t'({i_c, 1'b0}) << 52;
		len_s1 <= len_c;
		pos_s1 <= pos_c;
	end

	rsc_div #(.NW(64), .DW(HW), .STEP(4), .SBW(14)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s1),
		.num_i   (num_s1),
		.den_i   (len_s1),
		.sb_i    (pos_s1),
		.valid_o (div_valid),
		.quo_o   (div_quo),
		.sb_o    (div_pos)
	);

	rsc_mul64 #(.SBW(14)) u_mul_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (div_valid),
		.a_i     (div_quo),
		.b_i     (LOG2_10K_Q60),
		.sb_i    (div_pos),
		.valid_o (t_valid),
		.prod_o  (t_prod),
		.sb_o    (t_pos)
	);

	rsc_mul64 #(.SBW(30)) u_mul_ln2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (t_valid),
		.a_i     ({t_prod[111:64], 16'b0}),
		.b_i     (LN2_Q64),
		.sb_i    ({t_pos, t_prod[127:112]}),
		.valid_o (y_valid),
		.prod_o  (y_prod),
		.sb_o    (y_sb)
	);

	assign e_valid[0] = y_valid;
	assign e_term[0] = y_prod[127:64];
	assign e_mult[0] = y_prod[127:64];
	assign e_acc0[0] = y_prod[127:64];
	assign e_acc1[0] = '0;
	assign e_sb[0] = y_sb;

	for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
		rsc_term #(.K(j + 2), .SERIES(SERIES_EXP), .SBW(30)) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (e_valid[j]),
			.term_i  (e_term[j]),
			.mult_i  (e_mult[j]),
			.acc0_i  (e_acc0[j]),
			.acc1_i  (e_acc1[j]),
			.sb_i    (e_sb[j]),
			.valid_o (e_valid[j+1]),
			.term_o  (e_term[j+1]),
			.mult_o  (e_mult[j+1]),
			.acc0_o  (e_acc0[j+1]),
			.acc1_o  (e_acc1[j+1]),
			.sb_o    (e_sb[j+1])
		);
	end

	rsc_mul64 #(.SBW(30)) u_mul_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (e_valid[EXP_TERMS]),
		.a_i     (ONE_Q63 - (e_acc0[EXP_TERMS] >> 1)),
		.b_i     (INV_2PI_Q64),
		.sb_i    (e_sb[EXP_TERMS]),
		.valid_o (inv_valid),
		.prod_o  (inv_prod),
		.sb_o    (inv_sb)
	);

	always_ff @(posedge clk) begin
		if (inv_sb[15:0] >= 16'd64) begin
			turns_s2 <= '0;
		end else begin
			turns_s2 <= {inv_prod[126:64], 1'b0} >> inv_sb[5:0];
		end
		pos_s2 <= inv_sb[29:16];
	end

	rsc_mul64 #(.SBW(1)) u_mul_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s2),
		.a_i     ({50'b0, pos_s2}),
		.b_i     (turns_s2),
		.sb_i    (1'b0),
		.valid_o (ph_valid),
		.prod_o  (ph_prod),
		.sb_o    ()
	);

	rsc_mul64 #(.SBW(2)) u_mul_theta (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (ph_valid),
		.a_i     ({2'b0, ph_prod[61:0]}),
		.b_i     (HALF_PI_Q62),
		.sb_i    (ph_prod[63:62]),
		.valid_o (th_valid),
		.prod_o  (th_prod),
		.sb_o    (th_quad)
	);

	assign c_valid[0] = th_valid;
	assign c_term[0] = ONE_Q62;
	assign c_mult[0] = th_prod[125:62];
	assign c_acc0[0] = '0;
	assign c_acc1[0] = ONE_Q62;
	assign c_sb[0] = th_quad;

	for (genvar j = 0; j < TRIG_TERMS; j++) begin : g_trig
		rsc_term #(.K(j + 1), .SERIES(SERIES_TRIG), .SBW(2)) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (c_valid[j]),
			.term_i  (c_term[j]),
			.mult_i  (c_mult[j]),
			.acc0_i  (c_acc0[j]),
			.acc1_i  (c_acc1[j]),
			.sb_i    (c_sb[j]),
			.valid_o (c_valid[j+1]),
			.term_o  (c_term[j+1]),
			.mult_o  (c_mult[j+1]),
			.acc0_o  (c_acc0[j+1]),
			.acc1_o  (c_acc1[j+1]),
			.sb_o    (c_sb[j+1])
		);
	end

	always_comb begin
		sv_c = round_q14(c_acc0[TRIG_TERMS]);
		cv_c = round_q14(c_acc1[TRIG_TERMS]);
		unique case (c_sb[TRIG_TERMS])
			2'd0: begin
				sin_c = sv_c;
				cos_c = cv_c;
			end
			2'd1: begin
				sin_c = cv_c;
				cos_c = -sv_c;
			end
			2'd2: begin
				sin_c = -sv_c;
				cos_c = -cv_c;
			end
			2'd3: begin
				sin_c = -cv_c;
				cos_c = sv_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sin_s3 <= sin_c;
		cos_s3 <= cos_c;
	end

	assign done = valid_s3;
	assign sine_out = sin_s3;
	assign cosine_out = cos_s3;

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sine_out <= 16'sd16384 && sine_out >= -16'sd16384))
		else $error("sine out of range");

	a_not_both_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(sine_out == 16'sd0 && cosine_out == 16'sd0))
		else $error("sine and cosine both zero");

	a_head_dim_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_HEAD_DIM)
		|=> head_dim_q == $past(pwdata[8:0]))
		else $error("head_dim write lost");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import rsc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic signed [15:0] sine;
		logic signed [15:0] cosine;
	} trig_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [13:0] position = '0;
	logic [7:0] dim_index = '0;
	logic done;
	logic signed [15:0] sine_out;
	logic signed [15:0] cosine_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [8:0] head_dim_shadow = 9'd128;
	logic [1:0] convention_shadow = 2'd1;
	trig_pair_t pending_pairs[$];
	int mismatches = 0;
	int items_sent = 0;
	int pairs_checked = 0;
	int cycle_count = 0;
	bit idle_enabled = 1'b1;

	rope_sin_cos_generator_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.position(position), .dim_index(dim_index), .done(done),
		.sine_out(sine_out), .cosine_out(cosine_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] mul_upper(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [15:0] round_q14(logic signed [63:0] v);
		logic [63:0] u;
		if (v < 0) v = 0;
		if (v > $signed(ONE_Q62)) v = $signed(ONE_Q62);
		u = (v + 64'd140737488355328) >> 48;
		return u[15:0];
	endfunction

	function automatic trig_pair_t rope_angle_trig(logic [13:0] pos, logic [7:0] d,
			logic [8:0] hd_reg, logic [1:0] conv);
		logic [63:0] hd, len, e, i, x, t, n, f, y, term, s_acc, e_q63, turns, phase;
		logic [63:0] theta, quad;
		logic signed [63:0] sn, cs;
		logic signed [15:0] sv, cv, tmp;
		trig_pair_t r;
		hd = {55'd0, hd_reg} & ~64'd1;
		if (hd < 2) hd = 2;
		if (hd > MAX_HEAD_DIM_DEF) hd = MAX_HEAD_DIM_DEF;
		len = (conv >= 2) ? hd / 2 : hd;
		e = {56'd0, d} & ~64'd1;
		if (conv == 0) i = e / 2;
		else i = (e >= len / 2) ? e - len / 2 : e;
		x = ((2 * i) << 52) / len;
		t = mul_upper(x, LOG2_10K_Q60);
		n = t >> 48;
		f = t & ((64'd1 << 48) - 1);
		if (n >= 64) begin
			turns = 0;
		end else begin
			y = mul_upper(f << 16, LN2_Q64);
			term = y;
			s_acc = 0;
			for (int k = 1; k <= 20; k++) begin
				if (k > 1) term = mul_upper(term, y) / k;
				if (k & 1) s_acc += term;
				else s_acc -= term;
			end
			e_q63 = ONE_Q63 - (s_acc >> 1);
			turns = (mul_upper(e_q63, INV_2PI_Q64) << 1) >> n;
		end
		phase = {50'd0, pos} * turns;
		quad = phase >> 62;
		theta = mul_q62(phase & (ONE_Q62 - 1), HALF_PI_Q62);
		term = ONE_Q62;
		sn = 0;
		cs = $signed(ONE_Q62);
		for (int k = 1; k <= 27; k++) begin
			term = mul_q62(term, theta) / k;
			case (k & 3)
				1: sn += $signed(term);
				2: cs -= $signed(term);
				3: sn -= $signed(term);
				default: cs += $signed(term);
			endcase
		end
		sv = round_q14(sn);
		cv = round_q14(cs);
		case (quad[1:0])
			2'd0: ;
			2'd1: begin
				tmp = sv; sv = cv; cv = -tmp;
			end
			2'd2: begin
				sv = -sv; cv = -cv;
			end
			default: begin
				tmp = sv; sv = -cv; cv = tmp;
			end
		endcase
		r.sine = sv;
		r.cosine = cv;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("** rope_sin_cos_generator_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		trig_pair_t want;
		if (arst_n && done) begin
			if (pending_pairs.size() == 0) begin
				report_mismatch("unexpected transfer, sine", sine_out, 0);
			end else begin
				want = pending_pairs.pop_front();
				pairs_checked++;
				if (sine_out !== want.sine) report_mismatch("sine_out", sine_out, want.sine);
				if (cosine_out !== want.cosine)
					report_mismatch("cosine_out", cosine_out, want.cosine);
			end
		end
	end

	task automatic wait_results_drained();
		while (pending_pairs.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(logic reg_sel, logic [31:0] value);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_HEAD_DIM) head_dim_shadow = value[8:0];
		else convention_shadow = value[1:0];
	endtask

	task automatic set_config(logic [8:0] hd, logic [1:0] conv);
		reg_write(REG_HEAD_DIM, {$urandom} & 32'hFFFF_FE00 | hd);
		reg_write(REG_CONVENTION, {$urandom} & 32'hFFFF_FFFC | conv);
	endtask

	task automatic send_item(logic [13:0] pos, logic [7:0] d);
		int gap;
		trig_pair_t expected;
		start <= 1'b1;
		position <= pos;
		dim_index <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected = rope_angle_trig(pos, d, head_dim_shadow, convention_shadow);
		pending_pairs = {pending_pairs, expected};
		items_sent++;
		if (idle_enabled && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 9));
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_extremes();
		logic [13:0] poss[4] = '{14'd0, 14'd1, 14'd8191, 14'd16383};
		send_item(14'd16383, 8'd0);
		send_item(14'd16383, 8'd1);
		send_item(14'd12345, 8'd127);
		send_item(14'd12345, 8'd255);
		stop_sending();
		for (int c = 0; c < 4; c++) begin
			set_config(9'd256, c[1:0]);
			foreach (poss[j]) send_item(poss[j], (j == 3) ? 8'd255 : 8'(j * 37));
			stop_sending();
		end
		set_config(9'd2, 2'd2);
		send_item(14'd16383, 8'd0);
		send_item(14'd777, 8'd200);
		stop_sending();
		set_config(9'd511, 2'd0);
		send_item(14'd16383, 8'd255);
		stop_sending();
		set_config(9'd0, 2'd1);
		send_item(14'd300, 8'd1);
		stop_sending();
		set_config(9'd7, 2'd1);
		send_item(14'd9999, 8'd4);
		stop_sending();
	endtask

	task automatic run_random_phase(int count);
		logic [8:0] hd;
		int len;
		hd = head_dim_shadow & 9'h1FE;
		if (hd < 9'd2) hd = 9'd2;
		if (hd > 9'd256) hd = 9'd256;
		len = (convention_shadow >= 2'd2) ? int'(hd >> 1) : int'(hd);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 7) == 0) send_item(14'($urandom), 8'($urandom));
			else send_item(14'($urandom), 8'($urandom_range(0, len - 1)));
		end
		stop_sending();
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 10; ph++) begin
			if ($urandom_range(0, 3) == 0) set_config(9'($urandom), 2'($urandom));
			else set_config(9'(2 * $urandom_range(1, 128)), 2'($urandom_range(0, 2)));
			run_random_phase(90);
		end
	endtask

	task automatic test_pause_until_drained();
		run_random_phase(20);
		wait_results_drained();
		run_random_phase(20);
	endtask

	task automatic test_back_to_back();
		idle_enabled = 1'b0;
		set_config(9'd128, 2'd1);
		run_random_phase(60);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(14'd5000, 8'd10);
		stop_sending();
		test_directed_extremes();
		test_random_settings();
		test_pause_until_drained();
		test_back_to_back();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items and checked %0d sine/cosine pairs", items_sent, pairs_checked);
		$display("across all conventions, head dimensions 2..256 and odd or out-of-range values.");
		if (mismatches == 0 && pending_pairs.size() == 0) begin
			$display("** rope_sin_cos_generator_top: PASSED **");
		end else begin
			$display("** rope_sin_cos_generator_top: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/rsc_pkg.sv
design/rsc_div.sv
design/rsc_mul64.sv
design/rsc_term.sv
design/rope_sin_cos_generator_top.sv
dv/tb_top.sv
